[rtl/core/plp_pkg.sv]
`default_nettype none

package plp_pkg;

    // Width of the tested value, fixed by the stream format.
    localparam int VALUE_WIDTH = 32;

    // Default stream length before the position counter wraps.
    localparam int DEF_ARRAY_DEPTH = 1024;

    // Emitted position field width.
    localparam int POS_W = 10;

    // Packed stream widths.
    localparam int IN_TDATA_W  = VALUE_WIDTH;
    localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

    // Trial divisors never exceed the square root of the largest value.
    localparam int DIV_W = VALUE_WIDTH / 2 + 1;
    localparam int SQ_W  = 2 * DIV_W;

    // Remainder unit retires this many dividend bits per cycle.
    localparam int BITS_PER_CYCLE = 4;
    localparam int MOD_STEPS      = VALUE_WIDTH / BITS_PER_CYCLE;
    localparam int STEP_CNT_W     = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // First odd trial divisor.
    localparam int FIRST_DIV = 3;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // How the front part sorted a value.
    typedef enum logic [1:0] {
        K_NOT_PRIME,
        K_PRIME,
        K_TRIAL
    } t_kind;

    // One classified request, passed from front to back.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        t_kind                  kind;
        logic [POS_W-1:0]       pos;
        logic                   last;
    } t_job;

    // Back part sequencer.
    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_MOD,
        B_DONE
    } t_bstate;

endpackage

`default_nettype wire

[rtl/core/plp_front.sv]
`default_nettype none

module plp_front
    import plp_pkg::*;
#(
    parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_job                       o_job
);

    localparam int IDX_W = $clog2(ARRAY_DEPTH);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(ARRAY_DEPTH - 1);

    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic [VALUE_WIDTH-1:0] v;
    t_kind                  kind;

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;
    assign v             = s_axis_tdata[VALUE_WIDTH-1:0];

    // Negative values, zero, one and even values other than two are settled
    // here; odd values of three and up go to the trial divider.
    always_comb begin
        if (v[VALUE_WIDTH-1]) begin
            kind = K_NOT_PRIME;
        end else if (v == VALUE_WIDTH'(2)) begin
            kind = K_PRIME;
        end else if (!v[0] || v == VALUE_WIDTH'(1)) begin
            kind = K_NOT_PRIME;
        end else begin
            kind = K_TRIAL;
        end
    end

    assign o_job.value = v;
    assign o_job.kind  = kind;
    assign o_job.pos   = POS_W'(r_idx);
    assign o_job.last  = s_axis_tlast;

    always_comb begin
        if (s_axis_tlast || r_idx == IDX_MAX) begin
            n_idx = '0;
        end else begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

[rtl/core/plp_queue.sv]
`default_nettype none

module plp_queue
    import plp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/plp_back.sv]
`default_nettype none

module plp_back
    import plp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  t_job                        i_job,
    output logic                        o_pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser
);

    t_bstate                r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_n, n_n;
    logic [VALUE_WIDTH-1:0] r_nsh, n_nsh;
    logic [DIV_W-1:0]       r_d, n_d;
    logic [SQ_W-1:0]        r_sq, n_sq;
    logic [DIV_W-1:0]       r_rem, n_rem;
    logic [STEP_CNT_W-1:0]  r_cnt, n_cnt;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic                   r_last, n_last;
    logic                   r_prime, n_prime;
    logic                   r_seen, n_seen;
    logic                   r_out_valid, n_out_valid;
    logic [POS_W-1:0]       r_out_pos, n_out_pos;
    logic                   r_out_none, n_out_none;

    logic [DIV_W-1:0]       rem_step;
    logic [DIV_W:0]         rem_wide;
    logic                   emit;
    logic                   out_free;

    // Four restoring remainder steps, one dividend bit each.
    always_comb begin
        rem_step = r_rem;
        rem_wide = '0;
        for (int k = 0; k < BITS_PER_CYCLE; k++) begin
            rem_wide = {rem_step, r_nsh[VALUE_WIDTH-1-k]};
            if (rem_wide >= {1'b0, r_d}) begin
                rem_wide = rem_wide - {1'b0, r_d};
            end
            rem_step = rem_wide[DIV_W-1:0];
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign emit     = r_prime || (r_last && !r_seen);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_nsh       = r_nsh;
        n_d         = r_d;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_last      = r_last;
        n_prime     = r_prime;
        n_seen      = r_seen;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_pos   = r_out_pos;
        n_out_none  = r_out_none;
        o_pop       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_n     = i_job.value;
                    n_pos   = i_job.pos;
                    n_last  = i_job.last;
                    n_prime = i_job.kind == K_PRIME;
                    n_d     = DIV_W'(FIRST_DIV);
                    n_sq    = SQ_W'(FIRST_DIV * FIRST_DIV);
                    n_state = (i_job.kind == K_TRIAL) ? B_CHECK : B_DONE;
                end
            end
            B_CHECK: begin
                if (r_sq > SQ_W'(r_n)) begin
                    n_prime = 1'b1;
                    n_state = B_DONE;
                end else begin
                    n_rem   = '0;
                    n_nsh   = r_n;
                    n_cnt   = '0;
                    n_state = B_MOD;
                end
            end
            B_MOD: begin
                n_rem = rem_step;
                n_nsh = r_nsh << BITS_PER_CYCLE;
                n_cnt = r_cnt + STEP_CNT_W'(1);
                if (r_cnt == STEP_CNT_W'(MOD_STEPS - 1)) begin
                    if (rem_step == '0) begin
                        n_prime = 1'b0;
                        n_state = B_DONE;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        n_sq    = r_sq + (SQ_W'(r_d) << 2) + SQ_W'(4);
                        n_d     = r_d + DIV_W'(2);
                        n_state = B_CHECK;
                    end
                end
            end
            B_DONE: begin
                if (out_free) begin
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_out_pos   = r_prime ? r_pos : '0;
                        n_out_none  = !r_prime;
                    end
                    n_seen  = r_last ? 1'b0 : (r_seen || r_prime);
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_nsh      <= n_nsh;
        r_d        <= n_d;
        r_sq       <= n_sq;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_pos      <= n_pos;
        r_last     <= n_last;
        r_prime    <= n_prime;
        r_out_pos  <= n_out_pos;
        r_out_none <= n_out_none;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_pos);
    assign m_axis_tuser  = r_out_none;

endmodule

`default_nettype wire

[rtl/core/prime_position_lister.sv]
`default_nettype none
// A value that needs no trial division passes the queue, the back part's job registers and the output register.
// New requests enter the queue while the back part works on an earlier one, until the queue is full.
// An odd value of three or more adds a bound check and eight four-bit remainder steps per odd
// divisor tried, plus one closing bound check when none divides it. The divisor loop sets the rate.
// Reset: i_rst_n is synchronous and active low; it clears the position counter, the found flag,
// the queue and the output valid flag.

module prime_position_lister
    import plp_pkg::*;
#(
    parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: [31:0] value (two's complement)
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tlast: last_item, marks the final element of a stream
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: [9:0] position, [15:10] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: [0] none_found
    output logic                        m_axis_tuser
);

    // The front part numbers each request within its stream and sorts out
    // the values whose primality is obvious. Its output lands in a short
    // queue, so new requests keep arriving while the back part grinds
    // through trial division of an earlier one.
    logic q_full;
    logic push;
    t_job push_job;
    logic q_valid;
    logic pop;
    t_job pop_job;

    plp_front #(
        .ARRAY_DEPTH (ARRAY_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    plp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    // The back part tries odd divisors from three upward while the divisor
    // squared stays at or below the value, keeps the found flag of the
    // current stream, and posts either a prime's position or, at the end of
    // a stream with no prime, a none-found result into the output register.
    plp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (pop_job),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
